// ===== sv/touch_key_peak_detector_macros.svh =====
// Assertion macros shared by the touch key peak detector RTL.
`ifndef TOUCH_KEY_PEAK_DETECTOR_MACROS_SVH
`define TOUCH_KEY_PEAK_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKPD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tkpd_pkg.sv =====
// Shared types and constants for the touch key peak detector.
package tkpd_pkg;

    localparam int NCH                 = 4;
    localparam int SAMPLE_W            = 8;
    localparam int KEY_W               = 3;
    localparam int CFG_IDX_W           = 3;
    localparam int ROUNDS_LOG2_DEFAULT = 3;

    typedef logic [SAMPLE_W-1:0]          byte_t;
    typedef logic [NCH-1:0][SAMPLE_W-1:0] chan_array_t;
    typedef logic [KEY_W-1:0]             key_t;
    typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_CH0      = 3'd0,
        REG_OFFSET_CH1      = 3'd1,
        REG_OFFSET_CH2      = 3'd2,
        REG_OFFSET_CH3      = 3'd3,
        REG_PRESS_THRESHOLD = 3'd4,
        REG_RIVAL_THRESHOLD = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        byte_t press;
        byte_t rival;
    } thr_t;

    localparam key_t KEY_NONE = 3'd0;

    localparam byte_t OFFSET_CH0_RST = 8'd1;
    localparam byte_t OFFSET_CH1_RST = 8'd3;
    localparam byte_t OFFSET_CH2_RST = 8'd4;
    localparam byte_t OFFSET_CH3_RST = 8'd0;
    localparam byte_t PRESS_THR_RST  = 8'd8;
    localparam byte_t RIVAL_THR_RST  = 8'd8;

endpackage

// ===== sv/tkpd_chan.sv =====
// One touch channel: round accumulator, held peak and corrected difference.
module tkpd_chan #(
    parameter int ROUNDS_LOG2 = tkpd_pkg::ROUNDS_LOG2_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic          last,
    input  tkpd_pkg::byte_t sample,
    input  tkpd_pkg::byte_t offset,
    output tkpd_pkg::byte_t diff
);
    import tkpd_pkg::*;

    localparam int SUM_W = SAMPLE_W + ROUNDS_LOG2;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_total;
    byte_t            peak_reg;
    byte_t            peak_next;
    byte_t            avg;
    byte_t            diff_raw;

    assign sum_total = sum_reg + SUM_W'(sample);
    assign avg       = sum_total[SUM_W-1 -: SAMPLE_W];

    always_comb begin
        diff_raw = (avg > peak_reg) ? '0 : byte_t'(peak_reg - avg);
        diff     = (diff_raw > offset) ? byte_t'(diff_raw - offset) : diff_raw;
    end

    always_comb begin
        sum_next  = sum_reg;
        peak_next = peak_reg;
        if (step) begin
            if (last) begin
                sum_next = '0;
                if (avg > peak_reg) begin
                    peak_next = avg;
                end
            end else begin
                sum_next = sum_total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            peak_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
        end
    end

endmodule

// ===== sv/tkpd_key_sel.sv =====
// Key decision: strongest channel against press and rival thresholds.
module tkpd_key_sel (
    input  tkpd_pkg::chan_array_t diffs,
    input  tkpd_pkg::thr_t        thr,
    output tkpd_pkg::key_t        key_code
);
    import tkpd_pkg::*;

    byte_t                best;
    byte_t                second;
    logic [1:0]           best_idx;

    // Last maximum wins ties, so scan upward with >=.
    always_comb begin
        best     = diffs[0];
        best_idx = 2'd0;
        for (int i = 1; i < NCH; i++) begin
            if (diffs[i] >= best) begin
                best     = diffs[i];
                best_idx = 2'(i);
            end
        end
    end

    // Largest of the remaining channels; zero start is safe for unsigned.
    always_comb begin
        second = '0;
        for (int j = 0; j < NCH; j++) begin
            if (2'(j) != best_idx && diffs[j] > second) begin
                second = diffs[j];
            end
        end
    end

    always_comb begin
        if (best > thr.press && second < thr.rival) begin
            key_code = key_t'(best_idx) + key_t'(1);
        end else begin
            key_code = KEY_NONE;
        end
    end

endmodule

// ===== sv/touch_key_peak_detector.sv =====
// Touch key peak detector top level: input stage, four channels, key result register.
//
// Each transaction on the s_ channel carries one round of four 8-bit touch
// samples. Rounds are summed per channel in groups of 2**ROUNDS_LOG2 (8 by
// default); on the closing round of a group the sums are averaged by a right
// shift, compared against a per-channel peak that only ever rises (zero after
// reset), and turned into peak-minus-average differences, each reduced by its
// channel offset when it exceeds it. That closing round alone produces one
// m_ transaction: the four differences and a key code (0 = no key, else the
// winning channel index plus one; ties go to the higher channel). The block
// takes one round per clock unless the result register stalls it: a round sits in
// the input register while the channels work on it, and on a closing round the
// result register loads the channel outputs, which it then presents on m_.
// Only the result register can stall the flow: while
// it holds an untaken result, a closing round waits in the input register and
// s_ready drops; non-closing rounds keep moving. Configuration writes through
// cfg_* are always accepted (cfg_ready is tied high); indexes past the last
// register are dropped. Write configuration only while the block is idle.
module touch_key_peak_detector #(
    parameter int ROUNDS_LOG2 = tkpd_pkg::ROUNDS_LOG2_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // sample rounds
    input  logic               s_valid,
    output logic               s_ready,
    input  tkpd_pkg::byte_t    s_sample_ch0,
    input  tkpd_pkg::byte_t    s_sample_ch1,
    input  tkpd_pkg::byte_t    s_sample_ch2,
    input  tkpd_pkg::byte_t    s_sample_ch3,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output tkpd_pkg::key_t     m_key_code,
    output tkpd_pkg::byte_t    m_diff_ch0,
    output tkpd_pkg::byte_t    m_diff_ch1,
    output tkpd_pkg::byte_t    m_diff_ch2,
    output tkpd_pkg::byte_t    m_diff_ch3,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  tkpd_pkg::cfg_idx_t cfg_index,
    input  tkpd_pkg::byte_t    cfg_data
);
    import tkpd_pkg::*;

    `include "touch_key_peak_detector_macros.svh"

    localparam logic [ROUNDS_LOG2-1:0] LAST_ROUND = '1;

    // ---------------- configuration registers ----------------
    chan_array_t offset_reg;
    thr_t        thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg[0] <= OFFSET_CH0_RST;
            offset_reg[1] <= OFFSET_CH1_RST;
            offset_reg[2] <= OFFSET_CH2_RST;
            offset_reg[3] <= OFFSET_CH3_RST;
            thr_reg.press <= PRESS_THR_RST;
            thr_reg.rival <= RIVAL_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_OFFSET_CH0:      offset_reg[0] <= cfg_data;
                REG_OFFSET_CH1:      offset_reg[1] <= cfg_data;
                REG_OFFSET_CH2:      offset_reg[2] <= cfg_data;
                REG_OFFSET_CH3:      offset_reg[3] <= cfg_data;
                REG_PRESS_THRESHOLD: thr_reg.press <= cfg_data;
                REG_RIVAL_THRESHOLD: thr_reg.rival <= cfg_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------- input stage ----------------
    // Round counter runs at s_ acceptance; the stage carries a closing flag.
    logic                   s_fire;
    logic                   s1_go;
    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    chan_array_t            s1_sample_reg;
    logic [ROUNDS_LOG2-1:0] round_cnt_reg;
    logic                   m_valid_reg;

    // A closing round may move on only if the result register is free.
    assign s1_go   = s1_valid_reg && (!s1_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_go;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            round_cnt_reg <= '0;
        end else if (s_fire) begin
            s1_valid_reg  <= 1'b1;
            s1_last_reg   <= (round_cnt_reg == LAST_ROUND);
            round_cnt_reg <= round_cnt_reg + 1'b1;  // wraps after the last round
        end else if (s1_go) begin
            s1_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_sample_reg[0] <= s_sample_ch0;
            s1_sample_reg[1] <= s_sample_ch1;
            s1_sample_reg[2] <= s_sample_ch2;
            s1_sample_reg[3] <= s_sample_ch3;
        end
    end

    // ---------------- channels ----------------
    chan_array_t diffs;
    key_t        key_code;

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        tkpd_chan #(
            .ROUNDS_LOG2 (ROUNDS_LOG2)
        ) u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (s1_go),
            .last    (s1_last_reg),
            .sample  (s1_sample_reg[c]),
            .offset  (offset_reg[c]),
            .diff    (diffs[c])
        );
    end

    tkpd_key_sel u_key_sel (
        .diffs    (diffs),
        .thr      (thr_reg),
        .key_code (key_code)
    );

    // ---------------- result register ----------------
    key_t        m_key_reg;
    chan_array_t m_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_last_reg) begin
            m_key_reg  <= key_code;
            m_diff_reg <= diffs;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_key_code = m_key_reg;
    assign m_diff_ch0 = m_diff_reg[0];
    assign m_diff_ch1 = m_diff_reg[1];
    assign m_diff_ch2 = m_diff_reg[2];
    assign m_diff_ch3 = m_diff_reg[3];

    // ---------------- assertions ----------------
    `TKPD_ASSERT_NEXT(a_close_gives_result, aclk, aresetn, s1_go && s1_last_reg, m_valid_reg, "closing round did not load a result")
    `TKPD_ASSERT_NOW(a_stall_only_on_full, aclk, aresetn, !s_ready, s1_valid_reg && s1_last_reg && m_valid_reg && !m_ready, "input stalled without a waiting result")
    `TKPD_ASSERT_NEXT(a_count_wraps, aclk, aresetn, s_fire && round_cnt_reg == LAST_ROUND, round_cnt_reg == '0 && s1_last_reg, "round counter did not wrap on closing round")
    `TKPD_ASSERT_NOW(a_key_ch0_pressed, aclk, aresetn, m_valid_reg && m_key_reg == 3'd1, m_diff_reg[0] > thr_reg.press, "key 1 reported below press threshold")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the touch key peak detector: directed table, then random rounds.
module tb_top;
    import tkpd_pkg::*;

    // Group size follows the block's default parameter.
    localparam int GROUP_LOG2       = ROUNDS_LOG2_DEFAULT;
    localparam int GROUP_ROUNDS     = 1 << GROUP_LOG2;
    localparam int SUM_W            = SAMPLE_W + GROUP_LOG2;
    localparam int REG_COUNT        = int'(REG_RIVAL_THRESHOLD) + 1;
    localparam int CFG_IDX_TOP      = (1 << CFG_IDX_W) - 1;
    localparam int PHASES           = 8;
    localparam int ROUNDS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES    = 4;     // input reg and result reg, with margin
    localparam int QUIET_LIMIT      = 1000;  // cycles with no transaction on any channel
    localparam int MAX_REPORTS      = 10;
    localparam int RESET_CYCLES     = 9;

    // One m_ transaction: key code plus the four corrected differences.
    typedef struct packed {
        key_t        code;
        chan_array_t diff;
    } key_report_t;

    // Directed row: one round of samples; on a closing round the expected
    // report may be typed in (typed = 1), otherwise the predictor decides.
    typedef struct packed {
        chan_array_t smp;
        logic        typed;
        key_report_t want;
    } probe_row_t;

    // Packed channel arrays list channel 3 first.
    localparam chan_array_t ALL_LOW  = {4{8'h00}};
    localparam chan_array_t ALL_HIGH = {4{8'hff}};
    // Against a peak of 127: ch0 equals the peak, ch1 sits at its offset (3),
    // ch2 is 55 below (offset 4 -> 51), ch3 is 51 below (zero offset) -> tie.
    localparam chan_array_t SPREAD   = {8'd76, 8'd72, 8'd124, 8'd127};
    localparam chan_array_t SPREAD_D = {8'd51, 8'd51, 8'd3, 8'd0};

    localparam int PROBE_ROWS = 24;

    // Group 1: all zero, peaks stay 0, no key and zero diffs reported.
    // Group 2: half 0xff, half 0x00 -> average 127 beats the zero peaks, diffs 0.
    // Group 3: offset below/at/above the difference, zero offset, tie for largest
    //          (higher channel wins, second largest equals it -> no key).
    probe_row_t probe_table [PROBE_ROWS] = '{
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b1, '{KEY_NONE, '0}},
        '{ALL_HIGH, 1'b0, '{KEY_NONE, '0}},
        '{ALL_HIGH, 1'b0, '{KEY_NONE, '0}},
        '{ALL_HIGH, 1'b0, '{KEY_NONE, '0}},
        '{ALL_HIGH, 1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b0, '{KEY_NONE, '0}},
        '{ALL_LOW,  1'b1, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b0, '{KEY_NONE, '0}},
        '{SPREAD,   1'b1, '{KEY_NONE, SPREAD_D}}
    };

    // DUT signals; the inputs are all known from time zero.
    logic     aclk         = 1'b0;
    logic     aresetn      = 1'b0;
    logic     s_valid      = 1'b0;
    logic     s_ready;
    byte_t    s_sample_ch0 = '0;
    byte_t    s_sample_ch1 = '0;
    byte_t    s_sample_ch2 = '0;
    byte_t    s_sample_ch3 = '0;
    logic     m_valid;
    logic     m_ready      = 1'b0;
    key_t     m_key_code;
    byte_t    m_diff_ch0;
    byte_t    m_diff_ch1;
    byte_t    m_diff_ch2;
    byte_t    m_diff_ch3;
    logic     cfg_valid    = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index    = '0;
    byte_t    cfg_data     = '0;

    // Idle percentages for the current phase.
    int s_idle_pct  = 0;
    int m_stall_pct = 0;

    // Predictor state: own copy of registers, sums, group position and peaks.
    byte_t            offset_reg [NCH] = '{OFFSET_CH0_RST, OFFSET_CH1_RST,
                                           OFFSET_CH2_RST, OFFSET_CH3_RST};
    byte_t            press_reg        = PRESS_THR_RST;
    byte_t            rival_reg        = RIVAL_THR_RST;
    logic [SUM_W-1:0] sum_acc [NCH]    = '{default: '0};
    byte_t            peak_level [NCH] = '{default: '0};
    int               round_idx        = 0;

    key_report_t pending_reports [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          rounds_sent    = 0;

    touch_key_peak_detector #(
        .ROUNDS_LOG2 (GROUP_LOG2)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_ch0 (s_sample_ch0),
        .s_sample_ch1 (s_sample_ch1),
        .s_sample_ch2 (s_sample_ch2),
        .s_sample_ch3 (s_sample_ch3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_code   (m_key_code),
        .m_diff_ch0   (m_diff_ch0),
        .m_diff_ch1   (m_diff_ch1),
        .m_diff_ch2   (m_diff_ch2),
        .m_diff_ch3   (m_diff_ch3),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register write as seen by the predictor; indexes past the last are dropped.
    function automatic void latch_reg(input cfg_idx_t idx, input byte_t data);
        case (idx)
            REG_OFFSET_CH0, REG_OFFSET_CH1, REG_OFFSET_CH2, REG_OFFSET_CH3: begin
                offset_reg[idx[1:0]] = data;
            end
            REG_PRESS_THRESHOLD: begin
                press_reg = data;
            end
            REG_RIVAL_THRESHOLD: begin
                rival_reg = data;
            end
            default: begin
            end
        endcase
    endfunction

    // Adds one round to the sums; on the closing round of a group, averages,
    // updates peaks, corrects by offsets and picks the key.
    task automatic fold_round(input chan_array_t smp, output bit closed,
                              output key_report_t rep);
        byte_t avg;
        byte_t d;
        byte_t second;
        int    best_i;
        rep    = '0;
        closed = 1'b0;
        for (int ch = 0; ch < NCH; ch++) begin
            sum_acc[ch] = sum_acc[ch] + SUM_W'(smp[ch]);
        end
        if (round_idx != GROUP_ROUNDS - 1) begin
            round_idx++;
            return;
        end
        round_idx = 0;
        closed    = 1'b1;
        for (int ch = 0; ch < NCH; ch++) begin
            avg         = byte_t'(sum_acc[ch] >> GROUP_LOG2);
            sum_acc[ch] = '0;
            if (avg > peak_level[ch]) begin
                peak_level[ch] = avg;
                d = '0;
            end else begin
                d = peak_level[ch] - avg;
            end
            // offset only comes off when the difference is strictly above it
            if (d > offset_reg[ch]) begin
                d = d - offset_reg[ch];
            end
            rep.diff[ch] = d;
        end
        // last maximum wins, so ties go to the higher channel
        best_i = 0;
        for (int ch = 1; ch < NCH; ch++) begin
            if (rep.diff[ch] >= rep.diff[best_i]) begin
                best_i = ch;
            end
        end
        // runner-up: largest of the rest, may equal the winner
        second = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            if (ch != best_i && rep.diff[ch] > second) begin
                second = rep.diff[ch];
            end
        end
        if (rep.diff[best_i] > press_reg && second < rival_reg) begin
            rep.code = key_t'(best_i + 1);
        end else begin
            rep.code = KEY_NONE;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the
    // transaction, leaving valid high so a back-to-back round needs no toggle.
    task automatic send_round(input chan_array_t smp);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample_ch0 <= smp[0];
        s_sample_ch1 <= smp[1];
        s_sample_ch2 <= smp[2];
        s_sample_ch3 <= smp[3];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Same convention as send_round: the caller drops cfg_valid after a batch.
    task automatic write_reg(input cfg_idx_t idx, input byte_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        latch_reg(idx, data);
        @(negedge aclk);
    endtask

    // Accepts one round and files its expected report, if it closes a group.
    task automatic feed_round(input chan_array_t smp, input logic typed,
                              input key_report_t want);
        bit          closed;
        key_report_t rep;
        send_round(smp);
        fold_round(smp, closed, rep);
        rounds_sent++;
        if (closed) begin
            pending_reports.push_back(typed ? want : rep);
        end
    endtask

    // Result side: stall per the phase's percentage, driven at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_stall_pct);
    end

    // Result checker: compare each transaction with the oldest expectation.
    always @(posedge aclk) begin
        key_report_t got;
        key_report_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_key_code, {m_diff_ch3, m_diff_ch2, m_diff_ch1, m_diff_ch0}};
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result: key_code %0d diffs %0d %0d %0d %0d",
                             got.code, got.diff[0], got.diff[1], got.diff[2],
                             got.diff[3]);
                end
            end else begin
                want = pending_reports.pop_front();
                if (got.code !== want.code || got.diff[0] !== want.diff[0] ||
                    got.diff[1] !== want.diff[1] || got.diff[2] !== want.diff[2] ||
                    got.diff[3] !== want.diff[3]) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"mismatch: key_code exp %0d got %0d; ",
                                  "diffs exp %0d %0d %0d %0d got %0d %0d %0d %0d"},
                                 want.code, got.code,
                                 want.diff[0], want.diff[1], want.diff[2], want.diff[3],
                                 got.diff[0], got.diff[1], got.diff[2], got.diff[3]);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("touch_key_peak_detector verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        chan_array_t smp;
        chan_array_t level;
        byte_t       regs_next [REG_COUNT];
        int          shape;
        int          key_ch;
        int          v;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            // idling pattern: none, sender, receiver, both
            case (phase % 4)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 56; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 56; end
                default: begin s_idle_pct = 34; m_stall_pct = 34; end
            endcase

            // Register settings: reset values first, then all zero, all ones,
            // then random ones tuned so keys actually get reported.
            if (phase > 0) begin
                for (int i = 0; i < REG_COUNT; i++) begin
                    case (phase)
                        1: regs_next[i] = 8'h00;
                        2: regs_next[i] = 8'hff;
                        default: regs_next[i] = byte_t'($urandom_range(8));
                    endcase
                end
                if (phase > 2) begin
                    regs_next[REG_PRESS_THRESHOLD] = byte_t'($urandom_range(64));
                    regs_next[REG_RIVAL_THRESHOLD] = byte_t'($urandom_range(40, 4));
                end
                for (int i = 0; i < REG_COUNT; i++) begin
                    write_reg(cfg_idx_t'(i), regs_next[i]);
                end
            end
            // an index past the last register must change nothing
            write_reg(cfg_idx_t'($urandom_range(CFG_IDX_TOP, REG_COUNT)),
                      byte_t'($urandom_range(255)));
            cfg_valid <= 1'b0;

            if (phase == 0) begin
                for (int r = 0; r < PROBE_ROWS; r++) begin
                    feed_round(probe_table[r].smp, probe_table[r].typed,
                               probe_table[r].want);
                end
            end

            for (int n = 0; n < ROUNDS_PER_PHASE; n++) begin
                // New channel levels at each group boundary. Shapes:
                // 0-5 one channel well below the others (a press),
                // 6-7 two channels low (rivals), 8 random levels, 9 raw noise.
                if (rounds_sent % GROUP_ROUNDS == 0) begin
                    shape  = $urandom_range(9);
                    key_ch = $urandom_range(NCH - 1);
                    for (int ch = 0; ch < NCH; ch++) begin
                        if (shape <= 5) begin
                            level[ch] = (ch == key_ch) ? byte_t'($urandom_range(240))
                                                       : 8'd255 - byte_t'($urandom_range(12));
                        end else if (shape <= 7) begin
                            level[ch] = (ch == key_ch || ch == (key_ch + 1) % NCH)
                                      ? byte_t'($urandom_range(200))
                                      : 8'd255 - byte_t'($urandom_range(12));
                        end else begin
                            level[ch] = byte_t'($urandom_range(255));
                        end
                    end
                end
                for (int ch = 0; ch < NCH; ch++) begin
                    if (shape == 9) begin
                        smp[ch] = byte_t'($urandom_range(255));
                    end else begin
                        v = int'(level[ch]) + int'($urandom_range(6)) - 3;
                        if (v < 0) v = 0;
                        else if (v > 255) v = 255;
                        smp[ch] = byte_t'(v);
                    end
                end
                feed_round(smp, 1'b0, '0);
            end
            s_valid <= 1'b0;

            // Drain, then let a trailing non-closing round clear the pipeline
            // before the next register writes.
            while (pending_reports.size() != 0) @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end

        if (pending_reports.size() != 0) begin
            mismatch_count += pending_reports.size();
            $display("results never delivered: %0d", pending_reports.size());
        end
        if (mismatch_count == 0) begin
            $display("touch_key_peak_detector verification clean");
        end else begin
            $display("touch_key_peak_detector verification failed");
        end
        $finish;
    end

endmodule
